// ----- rtl/core/pce_pkg.sv -----
// Package for the Pearson correlation engine.
// Holds state codes, class codes, register indexes and threshold reset values.
// No dependencies.
`default_nettype none

package pce_pkg;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL, ST_VX1, ST_VX2, ST_VY1, ST_VY2, ST_NM1,
        ST_NM2, ST_RH, ST_PR, ST_SRCH, ST_SQ, ST_CMP, ST_OUT
    } t_state;

    localparam int THRESH_W = 15;
    localparam int CORR_W   = 16;

    typedef struct packed {
        logic [THRESH_W-1:0] th_vs;
        logic [THRESH_W-1:0] th_med;
        logic [THRESH_W-1:0] th_mod;
        logic [THRESH_W-1:0] th_low;
    } t_thresh;

    localparam logic [1:0] REG_VS  = 2'd0;
    localparam logic [1:0] REG_MED = 2'd1;
    localparam logic [1:0] REG_MOD = 2'd2;
    localparam logic [1:0] REG_LOW = 2'd3;

    localparam logic [THRESH_W-1:0] RST_VS  = 15'd22938;
    localparam logic [THRESH_W-1:0] RST_MED = 15'd16384;
    localparam logic [THRESH_W-1:0] RST_MOD = 15'd9830;
    localparam logic [THRESH_W-1:0] RST_LOW = 15'd3277;

    localparam logic [2:0] STR_VSTRONG = 3'd0;
    localparam logic [2:0] STR_MED     = 3'd1;
    localparam logic [2:0] STR_MOD     = 3'd2;
    localparam logic [2:0] STR_LOW     = 3'd3;
    localparam logic [2:0] STR_NEGL    = 3'd4;

    localparam logic [1:0] DIR_POS  = 2'd0;
    localparam logic [1:0] DIR_NEG  = 2'd1;
    localparam logic [1:0] DIR_NONE = 2'd2;

    localparam logic [15:0] MAG_FULL = 16'd32768;

endpackage

`default_nettype wire

// ----- rtl/core/pce_front.sv -----
// Front end: takes one sample pair per cycle unless stalled, squares and multiplies,
// accumulates. Pushes a snapshot of the sums into the queue on the last pair.
`default_nettype none

module pce_front #(
    parameter int SB   = 15,
    parameter int CW   = 11,
    parameter int MAXP = 1024,
    localparam int SW  = SB + CW,
    localparam int QW  = 2 * SB + CW,
    localparam int IW  = CW + 2 * SW + 3 * QW
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [SB-1:0] i_x,
    input  wire logic [SB-1:0] i_y,
    input  wire logic          i_last,
    output logic               o_push,
    input  wire logic          i_full,
    output logic [IW-1:0]      o_item
);

    logic          r_a_valid, r_a_ok, r_a_last;
    logic [SB-1:0]   r_a_x, r_a_y;
    logic [2*SB-1:0] r_a_xx, r_a_yy, r_a_xy;
    logic [CW-1:0] r_n, n_n;
    logic [SW-1:0] r_sx, r_sy, n_sx, n_sy;
    logic [QW-1:0] r_sxy, r_sxx, r_syy, n_sxy, n_sxx, n_syy;
    logic          adv, inc;

    // hold everything while a last pair waits for queue space
    assign adv     = !(r_a_valid && r_a_last && i_full);
    assign o_ready = adv;
    assign inc     = r_a_valid && r_a_ok && (r_n < CW'(MAXP));
    assign o_push  = r_a_valid && r_a_last && adv;

    always_comb begin
        n_n   = r_n;
        n_sx  = r_sx;
        n_sy  = r_sy;
        n_sxy = r_sxy;
        n_sxx = r_sxx;
        n_syy = r_syy;
        if (inc) begin
            n_n   = r_n + CW'(1);
            n_sx  = r_sx + SW'(r_a_x);
            n_sy  = r_sy + SW'(r_a_y);
            n_sxy = r_sxy + QW'(r_a_xy);
            n_sxx = r_sxx + QW'(r_a_xx);
            n_syy = r_syy + QW'(r_a_yy);
        end
        o_item = {n_n, n_sx, n_sy, n_sxy, n_sxx, n_syy};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_n       <= '0;
            r_sx      <= '0;
            r_sy      <= '0;
            r_sxy     <= '0;
            r_sxx     <= '0;
            r_syy     <= '0;
        end else if (adv) begin
            r_a_valid <= i_valid;
            if (o_push) begin
                r_n   <= '0;
                r_sx  <= '0;
                r_sy  <= '0;
                r_sxy <= '0;
                r_sxx <= '0;
                r_syy <= '0;
            end else begin
                r_n   <= n_n;
                r_sx  <= n_sx;
                r_sy  <= n_sy;
                r_sxy <= n_sxy;
                r_sxx <= n_sxx;
                r_syy <= n_syy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_valid) begin
            r_a_x    <= i_x;
            r_a_y    <= i_y;
            r_a_ok   <= (i_x != '0) && (i_y != '0);
            r_a_last <= i_last;
            r_a_xx   <= (2*SB)'(i_x) * (2*SB)'(i_x);
            r_a_yy   <= (2*SB)'(i_y) * (2*SB)'(i_y);
            r_a_xy   <= (2*SB)'(i_x) * (2*SB)'(i_y);
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/pce_queue.sv -----
// Two-entry queue between front and back of the correlation engine.
// Generic width; no package dependency.
`default_nettype none

module pce_queue #(
    parameter int W = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_data,
    output logic              o_full,
    output logic              o_empty
);

    logic [W-1:0] r_mem [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

endmodule

`default_nettype wire

// ----- rtl/core/pce_back.sv -----
// Back end: variance terms, covariance, and the Q1.15 coefficient by binary search.
// One shift-add multiplier shared by all steps. Depends on pce_pkg.
`default_nettype none

module pce_back #(
    parameter int SB  = 15,
    parameter int CW  = 11,
    localparam int SW = SB + CW,
    localparam int QW = 2 * SB + CW,
    localparam int IW = CW + 2 * SW + 3 * QW,
    localparam int PW = 4 * SB + 4 * CW + 32
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic [IW-1:0]   i_item,
    input  wire logic            i_empty,
    output logic                 o_pop,
    input  wire pce_pkg::t_thresh i_thresh,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output logic [15:0]          o_corr,
    output logic [2:0]           o_str,
    output logic [1:0]           o_dir,
    output logic                 o_degen,
    output logic [CW-1:0]        o_count
);

    pce_pkg::t_state r_state, n_state, r_ret, n_ret;
    logic [PW-1:0] r_ma, r_mb, r_mp, n_ma, n_mb, n_mp;
    logic [PW-1:0] r_tmp, r_vx, r_vy, r_pv, r_rhs, n_tmp, n_vx, n_vy, n_pv, n_rhs;
    logic          r_neg, n_neg, r_degen, n_degen;
    logic [15:0]   r_lo, r_hi, r_mid, n_lo, n_hi, n_mid;
    logic [CW-1:0] r_n, n_n;
    logic [SW-1:0] r_sx, r_sy, n_sx, n_sy;
    logic [QW-1:0] r_sxy, r_syy, n_sxy, n_syy;
    logic          r_oval, n_oval;
    logic [15:0]   r_ocorr, n_ocorr;
    logic [2:0]    r_ostr, n_ostr;
    logic [1:0]    r_odir, n_odir;
    logic          r_odeg, n_odeg;
    logic [CW-1:0] r_ocnt, n_ocnt;

    logic [CW-1:0] it_n;
    logic [SW-1:0] it_sx, it_sy;
    logic [QW-1:0] it_sxy, it_sxx, it_syy;
    logic [PW-1:0] diff, rdiff, vyv;
    logic          ge;
    logic [16:0]   mid17, k17;
    logic [15:0]   mag;

    assign {it_n, it_sx, it_sy, it_sxy, it_sxx, it_syy} = i_item;
    assign diff  = r_tmp - r_mp;
    assign rdiff = r_mp - r_tmp;
    assign ge    = (r_tmp >= r_mp);
    assign vyv   = ge ? diff : '0;
    assign mid17 = {1'b0, r_lo} + {1'b0, r_hi} + 17'd1;
    assign k17   = {mid17[16:1], 1'b0} - 17'd1;
    assign mag   = r_lo;

    always_comb begin
        n_state = r_state; n_ret = r_ret;
        n_ma = r_ma; n_mb = r_mb; n_mp = r_mp;
        n_tmp = r_tmp; n_vx = r_vx; n_vy = r_vy; n_pv = r_pv; n_rhs = r_rhs;
        n_neg = r_neg; n_degen = r_degen;
        n_lo = r_lo; n_hi = r_hi; n_mid = r_mid;
        n_n = r_n; n_sx = r_sx; n_sy = r_sy; n_sxy = r_sxy; n_syy = r_syy;
        n_oval = r_oval && !i_ready;
        n_ocorr = r_ocorr; n_ostr = r_ostr; n_odir = r_odir;
        n_odeg = r_odeg; n_ocnt = r_ocnt;
        o_pop = 1'b0;
        unique case (r_state)
            pce_pkg::ST_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    n_n = it_n; n_sx = it_sx; n_sy = it_sy;
                    n_sxy = it_sxy; n_syy = it_syy;
                    n_ma = PW'(it_sxx); n_mb = PW'(it_n); n_mp = '0;
                    n_ret = pce_pkg::ST_VX1; n_state = pce_pkg::ST_MUL;
                end
            end
            pce_pkg::ST_MUL: begin
                if (r_mb == '0) begin
                    n_state = r_ret;
                end else begin
                    if (r_mb[0]) n_mp = r_mp + r_ma;
                    n_ma = r_ma << 1;
                    n_mb = r_mb >> 1;
                end
            end
            pce_pkg::ST_VX1: begin
                n_tmp = r_mp;
                n_ma = PW'(r_sx); n_mb = PW'(r_sx); n_mp = '0;
                n_ret = pce_pkg::ST_VX2; n_state = pce_pkg::ST_MUL;
            end
            pce_pkg::ST_VX2: begin
                n_vx = ge ? diff : '0;
                n_ma = PW'(r_syy); n_mb = PW'(r_n); n_mp = '0;
                n_ret = pce_pkg::ST_VY1; n_state = pce_pkg::ST_MUL;
            end
            pce_pkg::ST_VY1: begin
                n_tmp = r_mp;
                n_ma = PW'(r_sy); n_mb = PW'(r_sy); n_mp = '0;
                n_ret = pce_pkg::ST_VY2; n_state = pce_pkg::ST_MUL;
            end
            pce_pkg::ST_VY2: begin
                n_vy = vyv;
                if (r_vx == '0 || vyv == '0) begin
                    n_degen = 1'b1;
                    n_lo = '0;
                    n_state = pce_pkg::ST_OUT;
                end else begin
                    n_degen = 1'b0;
                    n_ma = PW'(r_sxy); n_mb = PW'(r_n); n_mp = '0;
                    n_ret = pce_pkg::ST_NM1; n_state = pce_pkg::ST_MUL;
                end
            end
            pce_pkg::ST_NM1: begin
                n_tmp = r_mp;
                n_ma = PW'(r_sx); n_mb = PW'(r_sy); n_mp = '0;
                n_ret = pce_pkg::ST_NM2; n_state = pce_pkg::ST_MUL;
            end
            pce_pkg::ST_NM2: begin
                n_neg = !ge;
                n_ma = ge ? diff : rdiff;
                n_mb = ge ? diff : rdiff;
                n_mp = '0;
                n_ret = pce_pkg::ST_RH; n_state = pce_pkg::ST_MUL;
            end
            pce_pkg::ST_RH: begin
                n_rhs = r_mp << 32;
                n_ma = r_vx; n_mb = r_vy; n_mp = '0;
                n_ret = pce_pkg::ST_PR; n_state = pce_pkg::ST_MUL;
            end
            pce_pkg::ST_PR: begin
                n_pv = r_mp;
                n_lo = '0;
                n_hi = pce_pkg::MAG_FULL;
                n_state = pce_pkg::ST_SRCH;
            end
            pce_pkg::ST_SRCH: begin
                if (r_lo < r_hi) begin
                    n_mid = mid17[16:1];
                    n_ma = PW'(k17[15:0]); n_mb = PW'(k17[15:0]); n_mp = '0;
                    n_ret = pce_pkg::ST_SQ; n_state = pce_pkg::ST_MUL;
                end else begin
                    n_state = pce_pkg::ST_OUT;
                end
            end
            pce_pkg::ST_SQ: begin
                n_ma = r_pv; n_mb = r_mp; n_mp = '0;
                n_ret = pce_pkg::ST_CMP; n_state = pce_pkg::ST_MUL;
            end
            pce_pkg::ST_CMP: begin
                if (r_mp <= r_rhs) n_lo = r_mid;
                else               n_hi = r_mid - 16'd1;
                n_state = pce_pkg::ST_SRCH;
            end
            pce_pkg::ST_OUT: begin
                if (!r_oval || i_ready) begin
                    n_oval = 1'b1;
                    if (mag == '0)    n_ocorr = '0;
                    else if (r_neg)   n_ocorr = ~mag + 16'd1;
                    else if (mag[15]) n_ocorr = 16'h7FFF;
                    else              n_ocorr = mag;
                    if (mag > {1'b0, i_thresh.th_vs})       n_ostr = pce_pkg::STR_VSTRONG;
                    else if (mag > {1'b0, i_thresh.th_med}) n_ostr = pce_pkg::STR_MED;
                    else if (mag > {1'b0, i_thresh.th_mod}) n_ostr = pce_pkg::STR_MOD;
                    else if (mag > {1'b0, i_thresh.th_low}) n_ostr = pce_pkg::STR_LOW;
                    else                                    n_ostr = pce_pkg::STR_NEGL;
                    if (mag == '0)  n_odir = pce_pkg::DIR_NONE;
                    else if (r_neg) n_odir = pce_pkg::DIR_NEG;
                    else            n_odir = pce_pkg::DIR_POS;
                    n_odeg = r_degen;
                    n_ocnt = r_n;
                    n_state = pce_pkg::ST_IDLE;
                end
            end
            default: n_state = pce_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pce_pkg::ST_IDLE;
            r_ret   <= pce_pkg::ST_IDLE;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_oval  <= n_oval;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ma <= n_ma; r_mb <= n_mb; r_mp <= n_mp;
        r_tmp <= n_tmp; r_vx <= n_vx; r_vy <= n_vy; r_pv <= n_pv; r_rhs <= n_rhs;
        r_neg <= n_neg; r_degen <= n_degen;
        r_lo <= n_lo; r_hi <= n_hi; r_mid <= n_mid;
        r_n <= n_n; r_sx <= n_sx; r_sy <= n_sy; r_sxy <= n_sxy; r_syy <= n_syy;
        r_ocorr <= n_ocorr; r_ostr <= n_ostr; r_odir <= n_odir;
        r_odeg <= n_odeg; r_ocnt <= n_ocnt;
    end

    assign o_valid = r_oval;
    assign o_corr  = r_ocorr;
    assign o_str   = r_ostr;
    assign o_dir   = r_odir;
    assign o_degen = r_odeg;
    assign o_count = r_ocnt;

`ifndef SYNTHESIS
    a_mid_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pce_pkg::ST_CMP) |-> (r_mid != 16'd0))
        else $error("search midpoint is zero");
    a_hi_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pce_pkg::ST_SRCH) |-> (r_hi <= pce_pkg::MAG_FULL))
        else $error("search bound above full scale");
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_oval && r_odeg) |-> (r_ocorr == 16'd0 && r_odir == pce_pkg::DIR_NONE))
        else $error("degenerate result with nonzero coefficient");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/pearson_correlation_engine.sv -----
// Pearson correlation engine: one sample pair per cycle on the input stream;
// the front end accumulates count and sums, and on the pair marked last hands
// a snapshot to a two-entry queue, so accumulation of the next data set goes
// on while the back end computes. The back end runs every product through one
// shift-add multiplier (one multiplier bit per cycle) and finds the Q1.15
// coefficient by a binary search of at most 16 steps. The run of each product
// is set by the bit length of its multiplier operand, and a zero variance skips
// the covariance and search steps. The input stalls only on a last pair while
// the queue holds two pending data sets.
// Depends on pce_pkg, pce_front, pce_queue, pce_back.
`default_nettype none

module pearson_correlation_engine #(
    parameter int MAX_PAIRS   = 1024,
    parameter int SAMPLE_BITS = 15,
    localparam int CW  = $clog2(MAX_PAIRS + 1),
    localparam int TDW = ((2 * SAMPLE_BITS + 7) / 8) * 8,
    localparam int OW  = ((22 + CW + 7) / 8) * 8
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [TDW-1:0] s_tdata,   // sample_x, sample_y
    input  wire logic           s_tlast,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [OW-1:0]       m_tdata,   // corr_value, strength_class, direction,
                                           // degenerate, pair_count
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [3:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int SB = SAMPLE_BITS;
    localparam int IW = CW + 2 * (SB + CW) + 3 * (2 * SB + CW);

    pce_pkg::t_thresh r_thresh;
    logic [IW-1:0] item_in, item_out;
    logic          push, pop, q_full, q_empty;
    logic [15:0]   corr;
    logic [2:0]    str;
    logic [1:0]    dir;
    logic          degen;
    logic [CW-1:0] cnt;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh.th_vs  <= pce_pkg::RST_VS;
            r_thresh.th_med <= pce_pkg::RST_MED;
            r_thresh.th_mod <= pce_pkg::RST_MOD;
            r_thresh.th_low <= pce_pkg::RST_LOW;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                pce_pkg::REG_VS:  r_thresh.th_vs  <= pwdata[pce_pkg::THRESH_W-1:0];
                pce_pkg::REG_MED: r_thresh.th_med <= pwdata[pce_pkg::THRESH_W-1:0];
                pce_pkg::REG_MOD: r_thresh.th_mod <= pwdata[pce_pkg::THRESH_W-1:0];
                pce_pkg::REG_LOW: r_thresh.th_low <= pwdata[pce_pkg::THRESH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            pce_pkg::REG_VS:  prdata = 32'(r_thresh.th_vs);
            pce_pkg::REG_MED: prdata = 32'(r_thresh.th_med);
            pce_pkg::REG_MOD: prdata = 32'(r_thresh.th_mod);
            pce_pkg::REG_LOW: prdata = 32'(r_thresh.th_low);
            default:          prdata = '0;
        endcase
    end

    pce_front #(.SB(SB), .CW(CW), .MAXP(MAX_PAIRS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .o_ready (s_tready),
        .i_x     (s_tdata[SB-1:0]),
        .i_y     (s_tdata[2*SB-1:SB]),
        .i_last  (s_tlast),
        .o_push  (push),
        .i_full  (q_full),
        .o_item  (item_in)
    );

    pce_queue #(.W(IW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (item_in),
        .i_pop   (pop),
        .o_data  (item_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    pce_back #(.SB(SB), .CW(CW)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_out),
        .i_empty  (q_empty),
        .o_pop    (pop),
        .i_thresh (r_thresh),
        .o_valid  (m_tvalid),
        .i_ready  (m_tready),
        .o_corr   (corr),
        .o_str    (str),
        .o_dir    (dir),
        .o_degen  (degen),
        .o_count  (cnt)
    );

    assign m_tdata = OW'({cnt, degen, dir, str, corr});

endmodule

`default_nettype wire
